// ----- hdl/pan_tilt_pointing_angles_top_assert.svh -----
// Assertion macros for the pan/tilt pointing angle block.
// Used by pan_tilt_pointing_angles_top; needs clock and reset in scope.
`ifndef PAN_TILT_POINTING_ANGLES_TOP_ASSERT_SVH
`define PAN_TILT_POINTING_ANGLES_TOP_ASSERT_SVH

// same-cycle implication
`define PTPA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pointing angles check failed");

// next-cycle implication
`define PTPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pointing angles check failed");

`endif

// ----- hdl/ptpa_pkg.sv -----
// Shared widths, pipeline payload types and arithmetic helpers
// for the pan/tilt pointing angle block. No dependencies.
package ptpa_pkg;

   localparam int RW  = 33;  // relative position
   localparam int NW  = 25;  // block-normalized position
   localparam int AW  = 17;  // rotated axis component
   localparam int PW  = 32;  // quaternion product
   localparam int FW  = 36;  // axis accumulation
   localparam int XW  = 34;  // cross product term
   localparam int MW  = 42;  // axis times position
   localparam int QW  = 50;  // position square
   localparam int DW  = 44;  // dot product
   localparam int DUW = 28;  // up projection at position scale
   localparam int R2W = 50;  // squared length
   localparam int D2W = 55;  // squared up projection
   localparam int SW  = 52;  // square root working width
   localparam int HW  = 26;  // square root result bits
   localparam int CW  = 46;  // rotator x/y
   localparam int ZW  = 34;  // angle accumulator, Q.29

   localparam logic signed [FW-1:0] Q28_ONE     = 36'sd268435456;
   localparam logic signed [ZW-1:0] HALF_PI_Q29 = 34'sd843314856;
   localparam logic signed [34:0]   PAN_LIM     = 35'sd25736;
   localparam logic signed [34:0]   TILT_LIM    = 35'sd12868;
   localparam logic signed [FW-1:0] AXIS_LIM    = 36'sd32768;

   typedef struct packed {
      logic                  valid;
      logic                  degen;
      logic [SW-1:0]         rem;
      logic [SW-1:0]         root;
      logic signed [DW-1:0]  df;
      logic signed [DW-1:0]  dl;
      logic signed [DUW-1:0] du;
   } sqrt_type;

   typedef struct packed {
      logic                 valid;
      logic                 degen;
      logic                 zero;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cord_type;

   // round Q.28 to Q.14 and clamp
   function automatic logic signed [AW-1:0] to_q14(input logic signed [FW-1:0] v);
      logic signed [FW-1:0] t;
      t = (v + 36'sd8192) >>> 14;
      if (t > AXIS_LIM) t = AXIS_LIM;
      if (t < -AXIS_LIM) t = -AXIS_LIM;
      return AW'(t);
   endfunction

   function automatic logic signed [ZW-1:0] atan_q29(input int i);
      logic signed [ZW-1:0] a;
      unique case (i)
         0: a = 34'sd421657428;
         1: a = 34'sd248918915;
         2: a = 34'sd131521918;
         3: a = 34'sd66762579;
         4: a = 34'sd33510843;
         5: a = 34'sd16771758;
         6: a = 34'sd8387925;
         7: a = 34'sd4194219;
         8: a = 34'sd2097141;
         9: a = 34'sd1048575;
         default: a = (i < 30) ? (34'sd1 <<< (29 - i)) : '0;
      endcase
      return a;
   endfunction

   function automatic logic [5:0] lead_one(input logic [RW-1:0] m);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < RW; i++) begin
         if (m[i]) p = 6'(i);
      end
      return p;
   endfunction

   // fold the left half plane into the right one
   function automatic cord_type prerot(input logic v, input logic dg,
                                       input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y);
      cord_type c;
      c.valid = v;
      c.degen = dg;
      c.zero  = (x == '0) && (y == '0);
      c.x     = x;
      c.y     = y;
      c.z     = '0;
      if (x < 0) begin
         if (y >= 0) begin
            c.x = y;
            c.y = -x;
            c.z = HALF_PI_Q29;
         end else begin
            c.x = -y;
            c.y = x;
            c.z = -HALF_PI_Q29;
         end
      end
      return c;
   endfunction

   // Q.29 to Q3.13 with rounding, then clamp
   function automatic logic signed [15:0] round_angle(input logic signed [ZW-1:0] z,
                                                      input logic signed [34:0] lim);
      logic signed [34:0] t;
      t = (35'(z) + 35'sd32768) >>> 16;
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return 16'(t);
   endfunction

endpackage

// ----- hdl/ptpa_front.sv -----
// Front end: relative vector, rotated axes, block normalization, dot
// products and the square-root radicand. Nine register stages. Uses ptpa_pkg.
module ptpa_front
   import ptpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               req_valid,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_cam_x,
   input  logic signed [31:0] req_cam_y,
   input  logic signed [31:0] req_cam_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output sqrt_type           q
);

   localparam int P_YY = 0, P_ZZ = 1, P_XY = 2, P_WZ = 3, P_XZ = 4;
   localparam int P_WY = 5, P_WX = 6, P_YZ = 7, P_XX = 8;

   logic [7:0] vld_ff, vld_in;
   logic [7:1] dg_ff, dg_in;

   logic signed [RW-1:0]  r0_ff [3], r0_in [3];
   logic signed [15:0]    qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [PW-1:0]  p1_ff [9], p1_in [9];
   logic [RW-1:0]         m1_ff, m1_in;
   logic signed [RW-1:0]  r1_ff [3];
   logic signed [AW-1:0]  f2_ff [3], f2_in [3], u2_ff [3], u2_in [3];
   logic [5:0]            p2_ff, p2_in;
   logic signed [RW-1:0]  r2_ff [3];
   logic signed [XW-1:0]  x3_ff [6], x3_in [6];
   logic signed [NW-1:0]  n3_ff [3], n3_in [3];
   logic signed [AW-1:0]  f3_ff [3], u3_ff [3];
   logic signed [AW-1:0]  l4_ff [3], l4_in [3];
   logic signed [AW-1:0]  f4_ff [3], u4_ff [3];
   logic signed [NW-1:0]  n4_ff [3];
   logic signed [MW-1:0]  fr5_ff [3], lr5_ff [3], ur5_ff [3];
   logic signed [MW-1:0]  fr5_in [3], lr5_in [3], ur5_in [3];
   logic signed [QW-1:0]  rr5_ff [3], rr5_in [3];
   logic signed [DW-1:0]  df6_ff, df6_in, dl6_ff, dl6_in;
   logic signed [DUW-1:0] du6_ff, du6_in;
   logic [R2W-1:0]        rs6_ff, rs6_in;
   logic signed [DW-1:0]  df7_ff, dl7_ff;
   logic signed [DUW-1:0] du7_ff;
   logic [R2W-1:0]        rs7_ff;
   logic [D2W-1:0]        d27_ff, d27_in;
   sqrt_type              q_ff, q_in;

   logic signed [DW-1:0]  us6;
   logic signed [55:0]    rq6;
   logic signed [55:0]    dq7;

   assign vld_in = {vld_ff[6:0], req_valid};
   assign dg_in  = {dg_ff[6:1],
                    (r0_ff[0] == '0) && (r0_ff[1] == '0) && (r0_ff[2] == '0)};

   always_comb begin
      r0_in[0] = RW'(req_target_x) - RW'(req_cam_x);
      r0_in[1] = RW'(req_target_y) - RW'(req_cam_y);
      r0_in[2] = RW'(req_target_z) - RW'(req_cam_z);
   end

   // quaternion products and largest magnitude
   always_comb begin
      logic [RW-1:0] a [3];
      p1_in[P_YY] = qy_ff * qy_ff;
      p1_in[P_ZZ] = qz_ff * qz_ff;
      p1_in[P_XY] = qx_ff * qy_ff;
      p1_in[P_WZ] = qw_ff * qz_ff;
      p1_in[P_XZ] = qx_ff * qz_ff;
      p1_in[P_WY] = qw_ff * qy_ff;
      p1_in[P_WX] = qw_ff * qx_ff;
      p1_in[P_YZ] = qy_ff * qz_ff;
      p1_in[P_XX] = qx_ff * qx_ff;
      for (int k = 0; k < 3; k++) begin
         a[k] = r0_ff[k][RW-1] ? RW'(-r0_ff[k]) : RW'(r0_ff[k]);
      end
      m1_in = a[0];
      if (a[1] > m1_in) m1_in = a[1];
      if (a[2] > m1_in) m1_in = a[2];
   end

   // forward and up axes
   always_comb begin
      f2_in[0] = to_q14(Q28_ONE - ((FW'(p1_ff[P_YY]) + FW'(p1_ff[P_ZZ])) <<< 1));
      f2_in[1] = to_q14((FW'(p1_ff[P_XY]) + FW'(p1_ff[P_WZ])) <<< 1);
      f2_in[2] = to_q14((FW'(p1_ff[P_XZ]) - FW'(p1_ff[P_WY])) <<< 1);
      u2_in[0] = to_q14((FW'(p1_ff[P_XZ]) + FW'(p1_ff[P_WY])) <<< 1);
      u2_in[1] = to_q14((FW'(p1_ff[P_YZ]) - FW'(p1_ff[P_WX])) <<< 1);
      u2_in[2] = to_q14(Q28_ONE - ((FW'(p1_ff[P_XX]) + FW'(p1_ff[P_YY])) <<< 1));
      p2_in    = lead_one(m1_ff);
   end

   // cross-product terms and normalized position
   always_comb begin
      x3_in[0] = XW'(u2_ff[1]) * XW'(f2_ff[2]);
      x3_in[1] = XW'(u2_ff[2]) * XW'(f2_ff[1]);
      x3_in[2] = XW'(u2_ff[2]) * XW'(f2_ff[0]);
      x3_in[3] = XW'(u2_ff[0]) * XW'(f2_ff[2]);
      x3_in[4] = XW'(u2_ff[0]) * XW'(f2_ff[1]);
      x3_in[5] = XW'(u2_ff[1]) * XW'(f2_ff[0]);
      for (int k = 0; k < 3; k++) begin
         if (p2_ff > 6'd23) n3_in[k] = NW'(r2_ff[k] >>> (p2_ff - 6'd23));
         else n3_in[k] = NW'(r2_ff[k] <<< (6'd23 - p2_ff));
      end
   end

   always_comb begin
      l4_in[0] = to_q14(FW'(x3_ff[0]) - FW'(x3_ff[1]));
      l4_in[1] = to_q14(FW'(x3_ff[2]) - FW'(x3_ff[3]));
      l4_in[2] = to_q14(FW'(x3_ff[4]) - FW'(x3_ff[5]));
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fr5_in[k] = MW'(f4_ff[k]) * MW'(n4_ff[k]);
         lr5_in[k] = MW'(l4_ff[k]) * MW'(n4_ff[k]);
         ur5_in[k] = MW'(u4_ff[k]) * MW'(n4_ff[k]);
         rr5_in[k] = QW'(n4_ff[k]) * QW'(n4_ff[k]);
      end
   end

   always_comb begin
      df6_in = DW'(fr5_ff[0]) + DW'(fr5_ff[1]) + DW'(fr5_ff[2]);
      dl6_in = DW'(lr5_ff[0]) + DW'(lr5_ff[1]) + DW'(lr5_ff[2]);
      us6    = DW'(ur5_ff[0]) + DW'(ur5_ff[1]) + DW'(ur5_ff[2]);
      du6_in = DUW'(us6 >>> 14);
      rq6    = 56'(rr5_ff[0]) + 56'(rr5_ff[1]) + 56'(rr5_ff[2]);
      rs6_in = R2W'(rq6);
   end

   assign dq7    = 56'(du6_ff) * 56'(du6_ff);
   assign d27_in = D2W'(dq7);

   always_comb begin
      q_in.valid = vld_ff[7];
      q_in.degen = dg_ff[7];
      q_in.rem   = (D2W'(rs7_ff) > d27_ff) ? SW'(D2W'(rs7_ff) - d27_ff) : '0;
      q_in.root  = '0;
      q_in.df    = df7_ff;
      q_in.dl    = dl7_ff;
      q_in.du    = du7_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff  <= r0_in;
         qw_ff  <= req_quat_w;
         qx_ff  <= req_quat_x;
         qy_ff  <= req_quat_y;
         qz_ff  <= req_quat_z;
         p1_ff  <= p1_in;
         m1_ff  <= m1_in;
         r1_ff  <= r0_ff;
         f2_ff  <= f2_in;
         u2_ff  <= u2_in;
         p2_ff  <= p2_in;
         r2_ff  <= r1_ff;
         x3_ff  <= x3_in;
         n3_ff  <= n3_in;
         f3_ff  <= f2_ff;
         u3_ff  <= u2_ff;
         l4_ff  <= l4_in;
         f4_ff  <= f3_ff;
         u4_ff  <= u3_ff;
         n4_ff  <= n3_ff;
         fr5_ff <= fr5_in;
         lr5_ff <= lr5_in;
         ur5_ff <= ur5_in;
         rr5_ff <= rr5_in;
         df6_ff <= df6_in;
         dl6_ff <= dl6_in;
         du6_ff <= du6_in;
         rs6_ff <= rs6_in;
         df7_ff <= df6_ff;
         dl7_ff <= dl6_ff;
         du7_ff <= du6_ff;
         rs7_ff <= rs6_ff;
         d27_ff <= d27_in;
         dg_ff  <= dg_in;
      end
      if (reset) begin
         vld_ff     <= '0;
         q_ff.valid <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
         q_ff   <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// ----- hdl/ptpa_sqrt_cell.sv -----
// One digit step of the pipelined integer square root; carries the
// dot products alongside. Uses ptpa_pkg.
module ptpa_sqrt_cell
   import ptpa_pkg::*;
#(
   parameter int STEP = 0
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  sqrt_type d,
   output sqrt_type q
);

   localparam logic [SW-1:0] BIT = SW'(1) << (2 * STEP);

   sqrt_type      q_ff, q_in;
   logic [SW-1:0] trial;

   assign trial = d.root + BIT;

   always_comb begin
      q_in = d;
      if (d.rem >= trial) begin
         q_in.rem  = d.rem - trial;
         q_in.root = (d.root >> 1) + BIT;
      end else begin
         q_in.root = d.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_ff.valid <= 1'b0;
      else if (en) q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

// ----- hdl/ptpa_cordic_cell.sv -----
// One micro-rotation of the vectoring CORDIC, driving y toward zero
// and accumulating the angle in Q.29. Uses ptpa_pkg.
module ptpa_cordic_cell
   import ptpa_pkg::*;
#(
   parameter int IDX = 0
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  cord_type d,
   output cord_type q
);

   localparam logic signed [ZW-1:0] ANG = atan_q29(IDX);

   cord_type             q_ff, q_in;
   logic signed [CW-1:0] dx, dy;

   assign dx = d.y >>> IDX;
   assign dy = d.x >>> IDX;

   always_comb begin
      q_in = d;
      if (d.y >= 0) begin
         q_in.x = d.x + dx;
         q_in.y = d.y - dy;
         q_in.z = d.z + ANG;
      end else begin
         q_in.x = d.x - dx;
         q_in.y = d.y + dy;
         q_in.z = d.z - ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_ff.valid <= 1'b0;
      else if (en) q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

// ----- hdl/pan_tilt_pointing_angles_top.sv -----
// Pan/tilt pointing angles, top level: front end, square-root cell row,
// two CORDIC cell rows and the result register. Uses ptpa_pkg and the cells.
//
// Usage:
//   Input channel req_*: target and camera positions (Q16.16) and the
//   camera base quaternion (Q1.14). A transfer happens when req_valid is
//   high and req_stall is low.
//   Result channel rsp_*: pan (Q3.13, +-pi), tilt (Q2.13, +-pi/2) and the
//   degenerate flag, set with zero angles when target equals camera.
//   From transfer to rsp_valid an item passes through nine front-end
//   stages, 26 square-root cells, one CORDIC cell per stage and the result
//   register. Throughput is one item per cycle while the pipeline is not held.
//   The whole pipeline moves as one; it holds only while a result sits in
//   the result register and rsp_stall is high, and req_stall then follows.
//   Bubbles move through freely, so a new item is taken whenever the
//   result register is empty or being taken.
//   Reset (synchronous, active high) clears every valid bit; no item is
//   in flight afterwards and there is no other state.
`include "pan_tilt_pointing_angles_top_assert.svh"

module pan_tilt_pointing_angles_top
   import ptpa_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_cam_x,
   input  logic signed [31:0] req_cam_y,
   input  logic signed [31:0] req_cam_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pan_angle,
   output logic signed [14:0] rsp_tilt_angle,
   output logic               rsp_degenerate
);

   logic                en;
   sqrt_type            sq [HW+1];
   cord_type            pc [CORDIC_STAGES+1];
   cord_type            tc [CORDIC_STAGES+1];
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  rsp_pan_angle_ff, rsp_pan_angle_in;
   logic signed [14:0]  rsp_tilt_angle_ff, rsp_tilt_angle_in;
   logic                rsp_degenerate_ff, rsp_degenerate_in;
   logic signed [15:0]  tilt_wide;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   ptpa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .req_valid    (req_valid),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_target_z (req_target_z),
      .req_cam_x    (req_cam_x),
      .req_cam_y    (req_cam_y),
      .req_cam_z    (req_cam_z),
      .req_quat_w   (req_quat_w),
      .req_quat_x   (req_quat_x),
      .req_quat_y   (req_quat_y),
      .req_quat_z   (req_quat_z),
      .q            (sq[0])
   );

   for (genvar k = 0; k < HW; k++) begin : g_sqrt
      ptpa_sqrt_cell #(.STEP(HW - 1 - k)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (sq[k]),
         .q     (sq[k+1])
      );
   end

   assign pc[0] = prerot(sq[HW].valid, sq[HW].degen, CW'(sq[HW].df), CW'(sq[HW].dl));
   assign tc[0] = prerot(sq[HW].valid, sq[HW].degen,
                         CW'({1'b0, sq[HW].root[HW-1:0]}), CW'(sq[HW].du));

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      ptpa_cordic_cell #(.IDX(i)) u_pan (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (pc[i]),
         .q     (pc[i+1])
      );
      ptpa_cordic_cell #(.IDX(i)) u_tilt (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (tc[i]),
         .q     (tc[i+1])
      );
   end

   assign tilt_wide = round_angle(tc[CORDIC_STAGES].z, TILT_LIM);

   // degenerate items and all-zero vectors give zero angles
   always_comb begin
      rsp_valid_in      = pc[CORDIC_STAGES].valid;
      rsp_degenerate_in = pc[CORDIC_STAGES].degen;
      rsp_pan_angle_in  = '0;
      rsp_tilt_angle_in = '0;
      if (!pc[CORDIC_STAGES].degen) begin
         if (!pc[CORDIC_STAGES].zero)
            rsp_pan_angle_in = round_angle(pc[CORDIC_STAGES].z, PAN_LIM);
         if (!tc[CORDIC_STAGES].zero)
            rsp_tilt_angle_in = 15'(tilt_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (en) begin
         rsp_pan_angle_ff  <= rsp_pan_angle_in;
         rsp_tilt_angle_ff <= rsp_tilt_angle_in;
         rsp_degenerate_ff <= rsp_degenerate_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pan_angle  = rsp_pan_angle_ff;
   assign rsp_tilt_angle = rsp_tilt_angle_ff;
   assign rsp_degenerate = rsp_degenerate_ff;

   `PTPA_ASSERT_NOW(a_degen_zero, rsp_valid_ff && rsp_degenerate_ff,
                    rsp_pan_angle_ff == 16'sd0 && rsp_tilt_angle_ff == 15'sd0)
   `PTPA_ASSERT_NOW(a_pan_range, rsp_valid_ff,
                    rsp_pan_angle_ff <= 16'sd25736 && rsp_pan_angle_ff >= -16'sd25736)
   `PTPA_ASSERT_NOW(a_tilt_range, rsp_valid_ff,
                    rsp_tilt_angle_ff <= 15'sd12868 && rsp_tilt_angle_ff >= -15'sd12868)
   `PTPA_ASSERT_NEXT(a_last_cell_lands, pc[CORDIC_STAGES].valid && en, rsp_valid_ff)

endmodule

// ----- tb/sv/pan_tilt_pointing_angles_checker.sv -----
// Checker for the pan/tilt pointing angle block: watches both channels,
// predicts each result in fixed point and compares. Stand-alone, no package.
module pan_tilt_pointing_angles_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_cam_x,
   input  logic signed [31:0] req_cam_y,
   input  logic signed [31:0] req_cam_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_pan_angle,
   input  logic signed [14:0] rsp_tilt_angle,
   input  logic               rsp_degenerate,
   output int                 fail_count,
   output int                 pending,
   output int                 checked,
   output int                 degen_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES = 16;
   localparam longint HALF_PI_Z = 64'sd843314856;

   typedef struct packed {
      logic signed [15:0] pan;
      logic signed [14:0] tilt;
      logic               degen;
   } angles_t;

   angles_t angle_queue[$];

   function automatic longint clamp_to(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint round_axis(longint v);
      return clamp_to((v + 8192) >>> 14, 32768);
   endfunction

   function automatic longint arc_step(int i);
      longint head[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                           16771758, 8387925, 4194219, 2097141, 1048575};
      if (i < 10) return head[i];
      if (i < 30) return 64'sd1 <<< (29 - i);
      return 0;
   endfunction

   // vectoring CORDIC, angle in Q.29
   function automatic longint cordic_atan2(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = HALF_PI_Z;
         end else begin
            x = -y; y = t; z = -HALF_PI_Z;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += arc_step(i);
         end else begin
            x -= dx; y += dy; z -= arc_step(i);
         end
      end
      return z;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic angles_t point_camera(longint tx, longint ty, longint tz,
                                            longint cx, longint cy, longint cz,
                                            longint w, longint qx, longint qy,
                                            longint qz);
      angles_t a;
      longint r[3], f[3], u[3], l[3];
      longint df, dl, du, pan, tilt, m;
      longint unsigned r2, d2, h;
      int rs, ls;
      a = '0;
      r[0] = tx - cx; r[1] = ty - cy; r[2] = tz - cz;
      if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
         a.degen = 1'b1;
         return a;
      end
      f[0] = round_axis((64'sd1 <<< 28) - 2 * (qy * qy + qz * qz));
      f[1] = round_axis(2 * (qx * qy + w * qz));
      f[2] = round_axis(2 * (qx * qz - w * qy));
      u[0] = round_axis(2 * (qx * qz + w * qy));
      u[1] = round_axis(2 * (qy * qz - w * qx));
      u[2] = round_axis((64'sd1 <<< 28) - 2 * (qx * qx + qy * qy));
      l[0] = round_axis(u[1] * f[2] - u[2] * f[1]);
      l[1] = round_axis(u[2] * f[0] - u[0] * f[2]);
      l[2] = round_axis(u[0] * f[1] - u[1] * f[0]);
      // block-normalize so the largest component sits in [2^23, 2^24)
      m = 0;
      for (int k = 0; k < 3; k++) begin
         if ((r[k] < 0 ? -r[k] : r[k]) > m) m = r[k] < 0 ? -r[k] : r[k];
      end
      rs = 0; ls = 0;
      while (m >= (64'sd1 <<< 24)) begin m >>= 1; rs++; end
      while (m < (64'sd1 <<< 23)) begin m <<= 1; ls++; end
      for (int k = 0; k < 3; k++) r[k] = (r[k] >>> rs) <<< ls;
      df = f[0] * r[0] + f[1] * r[1] + f[2] * r[2];
      dl = l[0] * r[0] + l[1] * r[1] + l[2] * r[2];
      du = (u[0] * r[0] + u[1] * r[1] + u[2] * r[2]) >>> 14;
      r2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
      d2 = du * du;
      h = r2 > d2 ? floor_sqrt(r2 - d2) : 0;
      pan = clamp_to((cordic_atan2(dl, df) + 32768) >>> 16, 25736);
      tilt = clamp_to((cordic_atan2(du, longint'(h)) + 32768) >>> 16, 12868);
      a.pan = pan[15:0];
      a.tilt = tilt[14:0];
      return a;
   endfunction

   always @(posedge clock) begin
      angles_t want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         checked <= 0;
         degen_seen <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            angle_queue.push_back(point_camera(req_target_x, req_target_y, req_target_z,
                                               req_cam_x, req_cam_y, req_cam_z,
                                               req_quat_w, req_quat_x, req_quat_y,
                                               req_quat_z));
         end
         if (rsp_valid && !rsp_stall) begin
            checked <= checked + 1;
            if (angle_queue.size() == 0) begin
               $error("result transfer with nothing expected");
               errs++;
            end else begin
               want = angle_queue.pop_front();
               if (want.degen) degen_seen <= degen_seen + 1;
               if (rsp_pan_angle !== want.pan) begin
                  $error("pan_angle: expected %0d, got %0d", want.pan, rsp_pan_angle);
                  errs++;
               end
               if (rsp_tilt_angle !== want.tilt) begin
                  $error("tilt_angle: expected %0d, got %0d", want.tilt, rsp_tilt_angle);
                  errs++;
               end
               if (rsp_degenerate !== want.degen) begin
                  $error("degenerate: expected %0b, got %0b", want.degen,
                         rsp_degenerate);
                  errs++;
               end
            end
            fail_count <= fail_count + errs;
         end
      end
      pending <= angle_queue.size();
   end

endmodule

// ----- tb/sv/pan_tilt_pointing_angles_top_tb.sv -----
// Testbench top for the pan/tilt pointing angle block: directed and random
// poses with random gaps and stalls. Needs the RTL and the checker module.
module pan_tilt_pointing_angles_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_POSES = 1430;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic signed [31:0] tx, ty, tz, cx, cy, cz;
      logic signed [15:0] w, x, y, z;
   } pose_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic signed [31:0] req_cam_x = '0, req_cam_y = '0, req_cam_z = '0;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_pan_angle;
   logic signed [14:0] rsp_tilt_angle;
   logic               rsp_degenerate;
   int                 fail_count, pending, checked, degen_seen;
   bit                 quiet_phase;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pan_tilt_pointing_angles_top u_dut (.*);

   pan_tilt_pointing_angles_checker u_checker (.*);

   function automatic int gap_len();
      if (quiet_phase) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // random stall on the result side
   initial begin
      int n;
      forever begin
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   task automatic send_pose(pose_t p);
      int n;
      req_valid    <= 1'b1;
      req_target_x <= p.tx; req_target_y <= p.ty; req_target_z <= p.tz;
      req_cam_x    <= p.cx; req_cam_y    <= p.cy; req_cam_z    <= p.cz;
      req_quat_w   <= p.w;  req_quat_x   <= p.x;  req_quat_y   <= p.y;
      req_quat_z   <= p.z;
      do @(posedge clock); while (req_stall);
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] quat_part();
      case ($urandom_range(0, 4))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic pose_t random_pose();
      pose_t p;
      real a, b, c, d, n;
      int sel;
      p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         p.cx = $urandom; p.cy = $urandom; p.cz = $urandom;
      end else if (sel < 9) begin
         // camera close to the target, wrapping at the range ends
         p.cx = p.tx + ($urandom_range(0, 2000) - 1000);
         p.cy = p.ty + ($urandom_range(0, 2000) - 1000);
         p.cz = p.tz + ($urandom_range(0, 2) - 1);
      end else begin
         p.cx = p.tx; p.cy = p.ty; p.cz = p.tz;
      end
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
         a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
         c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
         n = $sqrt(a * a + b * b + c * c + d * d);
         if (n == 0.0) begin
            a = 1.0; n = 1.0;
         end
         p.w = 16'($rtoi(a / n * 16384.0)); p.x = 16'($rtoi(b / n * 16384.0));
         p.y = 16'($rtoi(c / n * 16384.0)); p.z = 16'($rtoi(d / n * 16384.0));
      end else begin
         p.w = quat_part(); p.x = quat_part(); p.y = quat_part(); p.z = quat_part();
      end
      return p;
   endfunction

   function automatic pose_t make_pose(int tx, int ty, int tz, int cx, int cy, int cz,
                                       int w, int x, int y, int z);
      pose_t p;
      p.tx = tx; p.ty = ty; p.tz = tz; p.cx = cx; p.cy = cy; p.cz = cz;
      p.w = 16'(w); p.x = 16'(x); p.y = 16'(y); p.z = 16'(z);
      return p;
   endfunction

   initial begin
      int lo, hi;
      lo = 32'sh8000_0000;
      hi = 32'sh7fff_ffff;
      quiet_phase = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // target along the x and y axes of an unrotated camera
      send_pose(make_pose(65536, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
      send_pose(make_pose(-65536, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
      send_pose(make_pose(0, 65536, 0, 0, 0, 0, 16384, 0, 0, 0));
      send_pose(make_pose(0, -65536, 0, 0, 0, 0, 16384, 0, 0, 0));
      // straight up or down: both pan arguments zero
      send_pose(make_pose(0, 0, 65536, 0, 0, 0, 16384, 0, 0, 0));
      send_pose(make_pose(0, 0, -1, 0, 0, 0, 16384, 0, 0, 0));
      // target on the camera
      send_pose(make_pose(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
      send_pose(make_pose(hi, lo, hi, hi, lo, hi, -16384, 16384, -16384, 16384));
      // widest separations
      send_pose(make_pose(hi, hi, hi, lo, lo, lo, 16384, 0, 0, 0));
      send_pose(make_pose(lo, lo, lo, hi, hi, hi, 0, 16384, 0, 0));
      send_pose(make_pose(hi, lo, 0, lo, hi, 0, 0, 0, 16384, 0));
      send_pose(make_pose(1, 0, 0, 0, 0, 0, 0, 0, 0, 16384));
      send_pose(make_pose(-1, -1, -1, 0, 0, 0, -16384, 0, 0, 0));
      // quaternions out of unit length
      send_pose(make_pose(65536, 65536, 65536, 0, 0, 0, 16384, 16384, 16384, 16384));
      send_pose(make_pose(65536, -65536, 65536, 0, 0, 0, -16384, -16384, -16384, -16384));
      send_pose(make_pose(65536, 3, 7, 0, 0, 0, 0, 0, 0, 0));
      send_pose(make_pose(-65536, 100, 0, 0, 0, 0, 11585, 0, 0, 11585));
      send_pose(make_pose(0, 0, 65536, 0, 0, 0, 11585, 0, 11585, 0));
      send_pose(make_pose(-5, 0, 65536, 0, 0, 0, 16384, 0, 16384, 0));
      quiet_phase = 1'b0;
      for (int i = 0; i < RANDOM_POSES; i++) begin
         if (i % 200 == 150) quiet_phase = 1'b1;
         if (i % 200 == 190) quiet_phase = 1'b0;
         send_pose(random_pose());
      end
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d pose results, %0d of them with target on the camera,",
               checked, degen_seen);
      $display("over axis, extreme-range and non-unit quaternion poses.");
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
